// ===== src/bsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsi_pkg
// Shared constants and types for the bitmap set with iterator.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int WORD_BITS_DEF = 64;

  typedef enum logic [2:0] {
    ACT_CONTAINS = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_FIRST    = 3'd4,
    ACT_NEXT     = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_DEAD  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN
  } state_t;

endpackage

// ===== src/bitmap_set_with_iterator.sv =====
// ----------------------------------------------------------------------------
// bitmap_set_with_iterator
// Set of small integers held as bitmap words in a RAM, with a member count
// and one iterator that walks the members in ascending order.
// ----------------------------------------------------------------------------
// In-range contains, insert and delete read one word, then modify and write back.
// Clear and the unused codes are answered from idle, as is a next on a
// dead iterator or past the top. Iterate first and next scan one RAM word a
// cycle. The result strobe follows the last cycle. Reset empties the set at
// once through per-word valid flags and kills the iterator; the receiver
// cannot stall, so results are never held.
module bitmap_set_with_iterator
  import bsi_pkg::*;
#(
  parameter int CAPACITY  = bsi_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = bsi_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [15:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic        hit,
  output logic [15:0] iter_value,
  output logic        iter_valid,
  output logic [16:0] member_total
);

  localparam int WC = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int WI = (WC > 1) ? $clog2(WC) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state, state_next;
  act_t               act, act_next;
  logic [WI-1:0]      word_sel, word_sel_next;
  logic [BW-1:0]      bit_sel, bit_sel_next;
  logic [WC-1:0]      valid, valid_next;
  logic [CW-1:0]      count, count_next;
  logic [PW-1:0]      pos, pos_next;
  logic               live, live_next;
  logic [WI-1:0]      scan_w, scan_w_next;
  logic [BW-1:0]      scan_lo, scan_lo_next;
  logic               done_next;
  stat_t              stat, stat_next;
  logic               hit_next;

  logic                 ram_we;
  logic [WI-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [WORD_BITS-1:0] word_eff, scan_word;
  logic                 ffs_found;
  logic [BW-1:0]        ffs_idx;
  logic                 cur_bit;
  logic                 in_range;
  logic [PW:0]          next_start;
  logic                 next_end;
  logic [WI-1:0]        next_word;
  logic [WI-1:0]        value_word;
  act_t                 act_in;

  assign act_in     = act_t'(action);
  assign in_range   = {1'b0, value} < 17'(CAPACITY);
  assign value_word = WI'(value >> BW);
  assign next_start = {1'b0, pos} + 1'b1;
  assign next_end   = next_start == (PW + 1)'(CAPACITY);
  assign next_word  = WI'(next_start >> BW);

  assign word_eff  = (state == ST_SCAN) ? (valid[scan_w] ? ram_rdata : '0)
                                        : (valid[word_sel] ? ram_rdata : '0);
  assign scan_word = word_eff & ({WORD_BITS{1'b1}} << scan_lo);
  assign cur_bit   = word_eff[bit_sel];
  assign ram_we    = (state == ST_UPDATE) &&
                     (((act == ACT_INSERT) && !cur_bit) || ((act == ACT_DELETE) && cur_bit));
  assign ram_wdata = word_eff ^ (WORD_BITS'(1) << bit_sel);

  always_comb begin
    if (state == ST_SCAN) begin
      ram_raddr = scan_w + 1'b1;
    end else begin
      case (act_in)
        ACT_FIRST: ram_raddr = '0;
        ACT_NEXT:  ram_raddr = next_word;
        default:   ram_raddr = value_word;
      endcase
    end
  end

  bsi_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WC),
    .AW    (WI)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_sel),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsi_ffs #(
    .W  (WORD_BITS),
    .BW (BW)
  ) u_ffs (
    .word  (scan_word),
    .found (ffs_found),
    .idx   (ffs_idx)
  );

  always_comb begin
    state_next    = state;
    act_next      = act;
    word_sel_next = word_sel;
    bit_sel_next  = bit_sel;
    valid_next    = valid;
    count_next    = count;
    pos_next      = pos;
    live_next     = live;
    scan_w_next   = scan_w;
    scan_lo_next  = scan_lo;
    done_next     = 1'b0;
    stat_next     = stat;
    hit_next      = hit;
    case (state)
      ST_IDLE: begin
        if (start) begin
          stat_next = STAT_OK;
          hit_next  = 1'b0;
          case (act_in)
            ACT_CONTAINS, ACT_INSERT, ACT_DELETE: begin
              if (!in_range) begin
                stat_next = STAT_RANGE;
                done_next = 1'b1;
              end else begin
                act_next      = act_in;
                word_sel_next = value_word;
                bit_sel_next  = value[BW-1:0];
                state_next    = ST_UPDATE;
              end
            end
            ACT_CLEAR: begin
              valid_next = '0;
              count_next = '0;
              done_next  = 1'b1;
            end
            ACT_FIRST: begin
              scan_w_next  = '0;
              scan_lo_next = '0;
              state_next   = ST_SCAN;
            end
            ACT_NEXT: begin
              if (!live) begin
                stat_next = STAT_DEAD;
                done_next = 1'b1;
              end else if (next_end) begin
                pos_next  = '0;
                live_next = 1'b0;
                done_next = 1'b1;
              end else begin
                scan_w_next  = next_word;
                scan_lo_next = next_start[BW-1:0];
                state_next   = ST_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        hit_next   = (act == ACT_CONTAINS) ? cur_bit : ram_we;
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (ram_we) begin
          valid_next[word_sel] = 1'b1;
          count_next = (act == ACT_INSERT) ? count + 1'b1 : count - 1'b1;
        end
      end
      ST_SCAN: begin
        scan_lo_next = '0;
        if (ffs_found) begin
          pos_next   = PW'({scan_w, ffs_idx});
          live_next  = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (scan_w == WI'(WC - 1)) begin
          pos_next   = '0;
          live_next  = 1'b0;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          scan_w_next = scan_w + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      count <= '0;
      pos   <= '0;
      live  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      count <= count_next;
      pos   <= pos_next;
      live  <= live_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    act      <= act_next;
    word_sel <= word_sel_next;
    bit_sel  <= bit_sel_next;
    scan_w   <= scan_w_next;
    scan_lo  <= scan_lo_next;
    stat     <= stat_next;
    hit      <= hit_next;
  end

  assign busy         = state != ST_IDLE;
  assign status       = stat;
  assign iter_valid   = live;
  assign iter_value   = live ? 16'(pos) : 16'd0;
  assign member_total = 17'(count);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still working");
  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor in progress");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= (CW + 1)'(CAPACITY))
    else $error("member count beyond capacity");
  a_dead_pos: assert property (@(posedge clk) disable iff (rst) !live |-> pos == '0)
    else $error("dead iterator holds a position");
  a_write_upd: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_UPDATE)
    else $error("word written outside an update");

endmodule

// ===== src/bsi_ram.sv =====
// ----------------------------------------------------------------------------
// bsi_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bsi_ffs.sv =====
// ----------------------------------------------------------------------------
// bsi_ffs
// Finds the lowest set bit of one bitmap word.
// ----------------------------------------------------------------------------
module bsi_ffs #(
  parameter int W  = 64,
  parameter int BW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  word,
  output logic          found,
  output logic [BW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = BW'(i);
      end
    end
    found = |word;
  end

endmodule

// ===== bench/tb_bitmap_set_with_iterator.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_set_with_iterator
// Self-checking bench for the bitmap set with iterator. A directed table
// covers reset, the range limits, word boundaries and the iterator corner
// cases. Weighted random items then follow in several sender idling phases.
// Every result strobe is checked against a set model or a fixed table reply.
// ----------------------------------------------------------------------------
module tb_bitmap_set_with_iterator;
  import bsi_pkg::*;

  localparam int CAPACITY = bsi_pkg::CAPACITY_DEF;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int PLAN_ROWS = 26;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [15:0] iter_value;
    logic        iter_valid;
    logic [16:0] member_total;
  } set_reply_t;

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] val;
    logic        fixed;
    set_reply_t  reply;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [15:0] value = '0;
  logic        done;
  logic [1:0]  status;
  logic        hit;
  logic [15:0] iter_value;
  logic        iter_valid;
  logic [16:0] member_total;

  logic [63:0] member_words [16];
  int unsigned member_cnt = 0;
  logic [9:0]  cursor_pos = '0;
  logic        cursor_live = 1'b0;

  set_reply_t  reply_q [$];
  int          fail_count = 0;
  int          idle_pct = 0;
  set_reply_t  got_reply;
  set_reply_t  want_reply;
  plan_row_t   plan [PLAN_ROWS];

  bitmap_set_with_iterator uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .value       (value),
    .done        (done),
    .status      (status),
    .hit         (hit),
    .iter_value  (iter_value),
    .iter_valid  (iter_valid),
    .member_total(member_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic void seek_cursor(int from);
    cursor_pos  = '0;
    cursor_live = 1'b0;
    for (int p = CAPACITY - 1; p >= from; p--) begin
      if (member_words[p >> 6][p & 63]) begin
        cursor_pos  = p[9:0];
        cursor_live = 1'b1;
      end
    end
  endfunction

  function automatic set_reply_t predict_reply(logic [2:0] act, logic [15:0] val);
    set_reply_t r;
    logic [3:0] w;
    logic [5:0] b;
    r = '0;
    w = val[9:6];
    b = val[5:0];
    if (act <= ACT_DELETE && val >= CAPACITY) begin
      r.status = STAT_RANGE;
    end else begin
      case (act)
        ACT_CONTAINS: r.hit = member_words[w][b];
        ACT_INSERT: begin
          if (!member_words[w][b]) begin
            member_words[w][b] = 1'b1;
            member_cnt++;
            r.hit = 1'b1;
          end
        end
        ACT_DELETE: begin
          if (member_words[w][b]) begin
            member_words[w][b] = 1'b0;
            member_cnt--;
            r.hit = 1'b1;
          end
        end
        ACT_CLEAR: begin
          foreach (member_words[i]) member_words[i] = '0;
          member_cnt = 0;
        end
        ACT_FIRST: seek_cursor(0);
        ACT_NEXT: begin
          if (!cursor_live) r.status = STAT_DEAD;
          else seek_cursor(int'(cursor_pos) + 1);
        end
        default: ;
      endcase
    end
    r.iter_value   = cursor_live ? {6'd0, cursor_pos} : 16'd0;
    r.iter_valid   = cursor_live;
    r.member_total = member_cnt[16:0];
    return r;
  endfunction

  task automatic issue_item(input logic [2:0] act, input logic [15:0] val,
                            input logic fixed, input set_reply_t typed);
    set_reply_t want;
    @(negedge clk);
    while (busy || $urandom_range(99) < idle_pct) begin
      start  = 1'b0;
      action = 3'($urandom);
      value  = 16'($urandom);
      @(negedge clk);
    end
    start  = 1'b1;
    action = act;
    value  = val;
    @(posedge clk);
    want = predict_reply(act, val);
    if (fixed) want = typed;
    reply_q = {reply_q, want};
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int roll;
    logic [15:0] v;
    roll = $urandom_range(99);
    if (roll < 40) v = 16'($urandom_range(CAPACITY - 1));
    else if (roll < 60) v = 16'($urandom_range(15));
    else if (roll < 75) v = 16'($urandom_range(CAPACITY - 1, CAPACITY - 16));
    else if (roll < 85) v = 16'($urandom_range(71, 56));
    else if (roll < 95) v = 16'($urandom_range(65535, CAPACITY));
    else v = 16'($urandom);
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      got_reply = {status, hit, iter_value, iter_valid, member_total};
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status=%0d hit=%0b iter=%0d valid=%0b total=%0d",
                   status, hit, iter_value, iter_valid, member_total);
      end else begin
        want_reply = reply_q.pop_front();
        if (got_reply !== want_reply) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: status %0d/%0d hit %0b/%0b iter %0d/%0d ",
                      "valid %0b/%0b total %0d/%0d (expected/actual)"},
                     want_reply.status, status, want_reply.hit, hit,
                     want_reply.iter_value, iter_value, want_reply.iter_valid, iter_valid,
                     want_reply.member_total, member_total);
        end
      end
    end
  end

  initial begin
    logic [2:0] act;
    int burst;
    int roll;
    int phase_idle [4];
    foreach (member_words[i]) member_words[i] = '0;
    phase_idle = '{0, 59, 0, 25};
    burst = 0;
    plan = '{
      '{ACT_NEXT,     16'd0,     1'b1, '{STAT_DEAD,  1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_FIRST,    16'd0,     1'b1, '{STAT_OK,    1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_CONTAINS, 16'd0,     1'b1, '{STAT_OK,    1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_INSERT,   16'hFFFF,  1'b1, '{STAT_RANGE, 1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_INSERT,   16'd1024,  1'b1, '{STAT_RANGE, 1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_DELETE,   16'hFFFF,  1'b1, '{STAT_RANGE, 1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_CONTAINS, 16'd1024,  1'b1, '{STAT_RANGE, 1'b0, 16'd0, 1'b0, 17'd0}},
      '{ACT_INSERT,   16'd0,     1'b1, '{STAT_OK,    1'b1, 16'd0, 1'b0, 17'd1}},
      '{ACT_INSERT,   16'd0,     1'b1, '{STAT_OK,    1'b0, 16'd0, 1'b0, 17'd1}},
      '{ACT_INSERT,   16'd1023,  1'b1, '{STAT_OK,    1'b1, 16'd0, 1'b0, 17'd2}},
      '{ACT_CONTAINS, 16'd1023,  1'b1, '{STAT_OK,    1'b1, 16'd0, 1'b0, 17'd2}},
      '{ACT_INSERT,   16'd63,    1'b0, '0},
      '{ACT_INSERT,   16'd64,    1'b0, '0},
      '{ACT_FIRST,    16'hFFFF,  1'b0, '0},
      '{ACT_NEXT,     16'd0,     1'b0, '0},
      '{ACT_DELETE,   16'd63,    1'b0, '0},
      '{ACT_NEXT,     16'd0,     1'b0, '0},
      '{ACT_NEXT,     16'd0,     1'b0, '0},
      '{ACT_NEXT,     16'd0,     1'b0, '0},
      '{ACT_NEXT,     16'd0,     1'b0, '0},
      '{ACT_FIRST,    16'd0,     1'b0, '0},
      '{ACT_CLEAR,    16'hFFFF,  1'b0, '0},
      '{ACT_NEXT,     16'd0,     1'b0, '0},
      '{ACT_SPARE6,   16'hFFFF,  1'b0, '0},
      '{ACT_SPARE7,   16'd0,     1'b0, '0},
      '{ACT_DELETE,   16'd5,     1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) issue_item(plan[i].act, plan[i].val, plan[i].fixed, plan[i].reply);
    drain_replies();

    foreach (phase_idle[ph]) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < 250; n++) begin
        if (burst > 0) begin
          act = ACT_NEXT;
          burst--;
        end else begin
          roll = $urandom_range(99);
          if (roll < 30) act = ACT_INSERT;
          else if (roll < 45) act = ACT_CONTAINS;
          else if (roll < 62) act = ACT_DELETE;
          else if (roll < 70) act = ACT_FIRST;
          else if (roll < 91) act = ACT_NEXT;
          else if (roll < 92) act = ACT_CLEAR;
          else if (roll < 94) act = ($urandom_range(1) != 0) ? ACT_SPARE7 : ACT_SPARE6;
          else begin
            act   = ACT_FIRST;
            burst = $urandom_range(40, 5);
          end
        end
        issue_item(act, pick_value(), 1'b0, '0);
      end
      drain_replies();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
